>>> src/ordered_insert_queue_defines.svh
// assertion macros for the ordered insert queue
`ifndef ORDERED_INSERT_QUEUE_DEFINES_SVH
`define ORDERED_INSERT_QUEUE_DEFINES_SVH

`ifndef SYNTH
`define OIQ_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("oiq assertion failed");
`define OIQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oiq assertion failed");
`define OIQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oiq assertion failed");
`else
`define OIQ_ASSERT(label, cond)
`define OIQ_ASSERT_IMP(label, ante, cons)
`define OIQ_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> src/oiq_pkg.sv
// shared constants and types of the ordered insert queue
package oiq_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int OP_W        = 2;
  localparam int STAT_W      = 2;

  localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 2'd1;
  localparam logic [OP_W-1:0] OP_REVERSE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ    = 2'd3;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic exec;
    logic rd_clr;
    logic load_read;
  } oiq_cmd_t;

  typedef struct packed {
    logic empty;
    logic rd_last;
  } oiq_sts_t;

endpackage

>>> src/oiq_datapath.sv
// entry cells, occupancy, read pointer and result register
`include "ordered_insert_queue_defines.svh"

module oiq_datapath import oiq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  oiq_cmd_t                      cmd,
  input  logic [OP_W-1:0]               in_operation,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output oiq_sts_t                      sts,
  output logic signed [VALUE_WIDTH-1:0] out_value_out,
  output logic [STAT_W-1:0]             out_status,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic                          out_last
);

  logic signed [VALUE_WIDTH-1:0] ent_r   [DEPTH];
  logic signed [VALUE_WIDTH-1:0] ent_nxt [DEPTH];
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] rd_idx_r;
  logic [CNT_W-1:0] pos;
  logic             found;
  logic             full;
  logic             is_add;

  logic signed [VALUE_WIDTH-1:0] out_value_r;
  logic [STAT_W-1:0]             out_status_r;
  logic [CNT_W-1:0]              out_count_r;
  logic                          out_last_r;

  assign full   = (occ_r == CNT_W'(DEPTH));
  assign is_add = (in_operation == OP_APPEND) || (in_operation == OP_INSERT);

  // insert position
  always_comb begin
    pos   = occ_r;
    found = 1'b0;
    if (in_operation == OP_APPEND) begin
      pos = occ_r;
    end else if (occ_r == '0 || in_value < ent_r[0]) begin
      pos = '0;
    end else begin
      for (int i = 1; i < DEPTH; i++) begin
        if (!found && CNT_W'(i) < occ_r && !(ent_r[i] < in_value)) begin
          pos   = CNT_W'(i);
          found = 1'b1;
        end
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] prev;
    logic [CNT_W-1:0]              idx;
    logic [CNT_W-1:0]              ridx;

    if (i == 0) begin : g_head
      assign prev = in_value;
    end else begin : g_body
      assign prev = ent_r[i-1];
    end

    assign idx  = CNT_W'(i);
    assign ridx = occ_r - CNT_W'(1) - idx;

    always_comb begin
      ent_nxt[i] = ent_r[i];
      case (in_operation)
        OP_APPEND, OP_INSERT: begin
          if (!full) begin
            if (idx == pos) begin
              ent_nxt[i] = in_value;
            end else if (idx > pos && idx <= occ_r) begin
              ent_nxt[i] = prev;
            end
          end
        end
        OP_REVERSE: begin
          if (idx < occ_r) begin
            ent_nxt[i] = ent_r[ridx[IDX_W-1:0]];
          end
        end
        default: ;
      endcase
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  assign occ_nxt = (is_add && !full) ? occ_r + CNT_W'(1) : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r    <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.exec) begin
        occ_r <= occ_nxt;
      end
      if (cmd.rd_clr) begin
        rd_idx_r <= '0;
      end else if (cmd.load_read) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  assign sts.empty   = (occ_r == '0);
  assign sts.rd_last = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == occ_r);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_value_r <= '0;
      out_count_r <= occ_nxt;
      out_last_r  <= 1'b1;
      if (is_add && full) begin
        out_status_r <= STAT_FULL;
      end else if (in_operation == OP_READ) begin
        out_status_r <= STAT_EMPTY;
      end else begin
        out_status_r <= STAT_OK;
      end
    end else if (cmd.load_read) begin
      out_value_r  <= ent_r[rd_idx_r];
      out_status_r <= STAT_OK;
      out_count_r  <= occ_r;
      out_last_r   <= sts.rd_last;
    end
  end

  assign out_value_out   = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

  `OIQ_ASSERT(a_occ_max, occ_r <= CNT_W'(DEPTH))
  `OIQ_ASSERT_NXT(a_full_drop, cmd.exec && is_add && full, occ_r == CNT_W'(DEPTH))
  `OIQ_ASSERT_IMP(a_rd_in_range, cmd.load_read, CNT_W'(rd_idx_r) < occ_r)

endmodule

>>> src/oiq_ctrl.sv
// sequencing of transactions and read out
`include "ordered_insert_queue_defines.svh"

module oiq_ctrl import oiq_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_operation,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  oiq_sts_t        sts,
  output oiq_cmd_t        cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;
  logic in_acc;
  logic rd_start;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == ST_IDLE && slot_free);
  assign in_acc    = in_valid && !in_stall;
  assign rd_start  = (in_operation == OP_READ) && !sts.empty;

  assign cmd.exec      = in_acc && !rd_start;
  assign cmd.rd_clr    = in_acc && rd_start;
  assign cmd.load_read = (state_r == ST_READ) && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.rd_clr) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (cmd.load_read && sts.rd_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.exec || cmd.load_read) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `OIQ_ASSERT_IMP(a_no_acc_read, state_r == ST_READ, in_stall)
  `OIQ_ASSERT_IMP(a_read_nonempty, state_r == ST_READ, !sts.empty)
  `OIQ_ASSERT_NXT(a_last_idle, cmd.load_read && sts.rd_last, state_r == ST_IDLE)

endmodule

>>> src/ordered_insert_queue.sv
// top level of the ordered insert queue
//
//  channel  direction  handshake          payload
//  in_      input      in_valid/in_stall   in_operation, in_value
//  out_     output     out_valid/out_stall out_value_out, out_status, out_entry_count, out_last
//
// append, insert and reverse are each done in the cell row and give one result
// a read holds the input while the entries held are read out in order, one entry per
// cycle while the output is not stalled, from a single read port (one result when empty)
// each result is registered and shows the cycle after it is formed
// synchronous active-low reset empties the queue; entry contents are not cleared
// a stalled result holds its register; the next transaction waits for the slot
module ordered_insert_queue import oiq_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [OP_W-1:0]               in_operation,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [VALUE_WIDTH-1:0] out_value_out,
  output logic [STAT_W-1:0]             out_status,
  output logic [CNT_W-1:0]              out_entry_count,
  output logic                          out_last
);

  oiq_cmd_t cmd;
  oiq_sts_t sts;

  oiq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  oiq_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .sts             (sts),
    .out_value_out   (out_value_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

endmodule

>>> verif/oiq_tb_pkg.sv
// scoreboard for the ordered insert queue: reference queue and pending result store
`timescale 1ns / 100ps
package oiq_tb_pkg;
  import oiq_pkg::*;

  typedef struct {
    logic signed [VALUE_WIDTH-1:0] value;
    logic [STAT_W-1:0]             status;
    logic [CNT_W-1:0]              count;
    logic                          last;
  } oiq_result_t;

  class oiq_order_checker;
    logic signed [VALUE_WIDTH-1:0] held[$];
    oiq_result_t                   pending_results[$];
    int                            errors;

    function new();
      errors = 0;
    endfunction

    function void queue_result(logic signed [VALUE_WIDTH-1:0] value,
                               logic [STAT_W-1:0] status, logic last);
      oiq_result_t r;
      r.value  = value;
      r.status = status;
      r.count  = CNT_W'(held.size());
      r.last   = last;
      pending_results.push_back(r);
    endfunction

    // update the reference queue for one accepted transaction
    function void note_input(logic [OP_W-1:0] op, logic signed [VALUE_WIDTH-1:0] val);
      int                            pos;
      int                            lo;
      int                            hi;
      logic signed [VALUE_WIDTH-1:0] swap;
      if (op == OP_APPEND || op == OP_INSERT) begin
        if (held.size() >= DEPTH) begin
          queue_result('0, STAT_FULL, 1'b1);
        end else begin
          if (op == OP_APPEND) begin
            pos = held.size();
          end else if (held.size() == 0 || val < held[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < held.size() && held[pos] < val) pos++;
          end
          held.insert(pos, val);
          queue_result('0, STAT_OK, 1'b1);
        end
      end else if (op == OP_REVERSE) begin
        lo = 0;
        hi = held.size() - 1;
        while (lo < hi) begin
          swap     = held[lo];
          held[lo] = held[hi];
          held[hi] = swap;
          lo++;
          hi--;
        end
        queue_result('0, STAT_OK, 1'b1);
      end else if (held.size() == 0) begin
        queue_result('0, STAT_EMPTY, 1'b1);
      end else begin
        for (int i = 0; i < held.size(); i++)
          queue_result(held[i], STAT_OK, i == held.size() - 1);
      end
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void check_result(logic signed [VALUE_WIDTH-1:0] value, logic [STAT_W-1:0] status,
                               logic [CNT_W-1:0] count, logic last);
      oiq_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value_out %0d status %0d entry_count %0d last %0d",
                 $time, value, status, count, last);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (want.value !== value) begin
        $display("%0t: value_out expected %0d actual %0d", $time, want.value, value);
        errors++;
      end
      if (want.status !== status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
      if (want.count !== count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, want.count, count);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
// top of the ordered insert queue testbench: clock, reset, drivers and monitor
`timescale 1ns / 100ps
module tb_top;
  import oiq_pkg::*;
  import oiq_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 75;
  localparam int CALM_ITEMS   = 20;
  localparam int SETTLE       = 20;
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [OP_W-1:0]               in_operation = OP_APPEND;
  logic signed [VALUE_WIDTH-1:0] in_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [VALUE_WIDTH-1:0] out_value_out;
  logic [STAT_W-1:0]             out_status;
  logic [CNT_W-1:0]              out_entry_count;
  logic                          out_last;

  oiq_order_checker sb = new();
  bit               calm = 1'b0;
  int               cycle_count = 0;
  int               stall_left = 0;

  ordered_insert_queue uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value_out   (out_value_out),
    .out_status      (out_status),
    .out_entry_count (out_entry_count),
    .out_last        (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (!calm && rst_n && stall_left == 0 && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 6);
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // sample at the falling edge, act on the following rising edge
  initial begin
    logic                          take;
    logic signed [VALUE_WIDTH-1:0] v;
    logic [STAT_W-1:0]             s;
    logic [CNT_W-1:0]              c;
    logic                          l;
    forever begin
      @(negedge clk);
      take = rst_n && out_valid && !out_stall;
      v    = out_value_out;
      s    = out_status;
      c    = out_entry_count;
      l    = out_last;
      @(posedge clk);
      if (take) sb.check_result(v, s, c, l);
    end
  end

  task automatic send_item(input logic [OP_W-1:0] op, input logic signed [VALUE_WIDTH-1:0] val);
    logic accepted;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid     <= 1'b0;
      in_operation <= OP_W'($urandom_range(0, 3));
      in_value     <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_value     <= val;
    do begin
      @(negedge clk);
      accepted = !in_stall;
      @(posedge clk);
    end while (!accepted);
    sb.note_input(op, val);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0, 1: return VALUE_WIDTH'($signed($urandom_range(0, 16)) - 8);
      2: begin
        case ($urandom_range(0, 3))
          0: return VMAX;
          1: return VMIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int               r;
    logic [OP_W-1:0]  op;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue, single entry and equal value placement
    send_item(OP_READ, pick_value());
    send_item(OP_REVERSE, pick_value());
    send_item(OP_INSERT, 10);
    send_item(OP_REVERSE, pick_value());
    send_item(OP_INSERT, 10);
    send_item(OP_INSERT, 7);
    send_item(OP_INSERT, 10);
    send_item(OP_INSERT, VMIN);
    send_item(OP_APPEND, VMAX);
    send_item(OP_READ, '0);
    send_item(OP_REVERSE, '0);
    send_item(OP_INSERT, 8);
    send_item(OP_READ, '0);
    // fill up with random content
    while (sb.held.size() < DEPTH) begin
      op = ($urandom_range(0, 2) == 0) ? OP_APPEND : OP_INSERT;
      send_item(op, pick_value());
    end
    send_item(OP_APPEND, VMAX);
    send_item(OP_INSERT, VMIN);
    send_item(OP_READ, '0);
    drain();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 24) == 0) drain();
      r = $urandom_range(0, 99);
      if (r < 25) op = OP_APPEND;
      else if (r < 50) op = OP_INSERT;
      else if (r < 70) op = OP_REVERSE;
      else op = OP_READ;
      send_item(op, pick_value());
    end
    in_valid <= 1'b0;

    while (sb.outstanding() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
